// ===== src/dlc_pkg.sv =====
// ----------------------------------------------------------------------------
// dlc_pkg: shared definitions for the direct linear convolution block
// Field widths, default parameters, opcodes and the control structs passed
// from the sequencer to the tap cells and the output stage.
// ----------------------------------------------------------------------------
package dlc_pkg;

	// fixed field widths
	localparam int RESULT_BITS  = 40;
	localparam int CFG_BITS     = 7;
	localparam int TAP_IDX_BITS = 6;

	// parameter defaults
	localparam int DEF_MAX_TAPS    = 64;
	localparam int DEF_SAMPLE_BITS = 16;

	// input opcodes
	localparam logic OP_TAP    = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	// controls broadcast along the cell chain
	typedef struct packed {
		logic shift;   // advance the delay line by one sample
		logic zero_in; // shift a zero instead of the input sample
		logic clear;   // zero the whole delay line
		logic tap_we;  // write the addressed tap
	} cell_ctl_t;

	// output register controls
	typedef struct packed {
		logic cap;     // load the chain sum into the output register
		logic last;    // the loaded result ends the convolution
	} out_ctl_t;

endpackage

// ===== src/dlc_cell.sv =====
// ----------------------------------------------------------------------------
// dlc_cell: one tap of the convolution chain
// Holds one tap and one delay-line sample, forms their product and adds it
// to the partial sum coming from the previous cell.
// ----------------------------------------------------------------------------
module dlc_cell import dlc_pkg::*; #(
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
	parameter int IDX         = 0,
	parameter int KW          = 7
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cell_ctl_t                     ctl,
	input  logic [TAP_IDX_BITS-1:0]       tap_index,
	input  logic signed [SAMPLE_BITS-1:0] tap_value,
	input  logic [KW-1:0]                 k_eff,
	input  logic signed [SAMPLE_BITS-1:0] samp_in,
	output logic signed [SAMPLE_BITS-1:0] samp_out,
	input  logic signed [RESULT_BITS-1:0] psum_in,
	output logic signed [RESULT_BITS-1:0] psum_out
);

	logic signed [SAMPLE_BITS-1:0]   samp_q;
	logic signed [SAMPLE_BITS-1:0]   tap_q;
	logic signed [2*SAMPLE_BITS-1:0] mul;
	logic signed [RESULT_BITS-1:0]   prod_q;
	logic signed [RESULT_BITS-1:0]   psum_q;
	logic                            active;
	logic                            tap_hit;

	assign active  = 32'(k_eff) > IDX;
	assign tap_hit = ctl.tap_we && (32'(tap_index) == IDX);

	// delay-line stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samp_q <= '0;
		end else if (ctl.clear) begin
			samp_q <= '0;
		end else if (ctl.shift) begin
			samp_q <= samp_in;
		end
	end

	// tap register, loaded by index
	always_ff @(posedge clk) begin
		if (tap_hit) begin
			tap_q <= tap_value;
		end
	end

	// product, then add into the passing sum; taps beyond the kernel add zero
	assign mul = tap_q * samp_q;

	always_ff @(posedge clk) begin
		prod_q <= active ? RESULT_BITS'(mul) : '0;
		psum_q <= psum_in + prod_q;
	end

	assign samp_out = samp_q;
	assign psum_out = psum_q;

endmodule

// ===== src/dlc_ctrl.sv =====
// ----------------------------------------------------------------------------
// dlc_ctrl: sequencer for the convolution chain
// Accepts tap writes and samples, waits for the sum to settle along the
// chain, loads results and runs the zero-fed tail after a last sample.
// ----------------------------------------------------------------------------
module dlc_ctrl import dlc_pkg::*; #(
	parameter int MAX_TAPS = DEF_MAX_TAPS,
	parameter int KW       = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          opcode,
	input  logic          last_sample,
	input  logic [KW-1:0] k_eff,
	input  logic          out_ready,
	output logic          out_valid,
	output cell_ctl_t     ctl,
	output out_ctl_t      octl
);

	// the chain sum is valid once the settle counter reaches this value after a shift
	localparam int DONE_CNT = MAX_TAPS + 1;
	localparam int CW       = $clog2(DONE_CNT + 1);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic [KW-1:0]   tail_q;
	logic            last_q;
	logic            out_valid_q;
	logic            slot_free;
	logic            settled;
	logic            more_tail;

	assign in_ready  = (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || out_ready;
	assign settled   = (cnt_q == CW'(DONE_CNT));
	assign more_tail = last_q && (tail_q != '0);

	// decode of the strobes
	always_comb begin
		ctl       = '0;
		octl      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					ctl.tap_we = (opcode == OP_TAP);
					ctl.shift  = (opcode == OP_SAMPLE);
				end
			end
			ST_RUN: begin
				if (settled && slot_free) begin
					octl.cap     = 1'b1;
					octl.last    = last_q && (tail_q == '0);
					ctl.shift    = more_tail;
					ctl.zero_in  = more_tail;
					ctl.clear    = last_q && !more_tail;
				end
			end
			default: begin
				ctl  = '0;
				octl = '0;
			end
		endcase
	end

	// state, settle counter and tail count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			tail_q  <= '0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && opcode == OP_SAMPLE) begin
						state_q <= ST_RUN;
						cnt_q   <= '0;
						last_q  <= last_sample;
						tail_q  <= k_eff - KW'(1);
					end
				end
				ST_RUN: begin
					if (!settled) begin
						cnt_q <= cnt_q + CW'(1);
					end else if (slot_free) begin
						if (more_tail) begin
							cnt_q  <= '0;
							tail_q <= tail_q - KW'(1);
						end else begin
							state_q <= ST_IDLE;
							last_q  <= 1'b0;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output beat pending flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (octl.cap) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/direct_linear_convolution.sv =====
// ----------------------------------------------------------------------------
// direct_linear_convolution: full linear convolution of a sample stream
// Chain of MAX_TAPS tap cells, a sequencer and a registered result port.
// ----------------------------------------------------------------------------
// A beat with opcode 0 writes one kernel tap. A beat with opcode 1 shifts a
// sample into the delay line held across the cell chain; the partial sum then
// walks cell to cell through one product register and MAX_TAPS sum registers.
// The next input beat is taken only once the sample's final result is loaded
// into the output register, which waits while an earlier result is pending.
// After a sample marked last, kernel_length-1 tail results follow, the final
// one flagged with last_result, and the delay line is cleared. Results are raw
// Q10.30 sums truncated to 40 bits. kernel_length is written through
// cfg_we/cfg_wdata; the user must write it only while the block is idle, and
// the block itself does not enforce this. Values of zero or above MAX_TAPS
// act as 1 or MAX_TAPS.
module direct_linear_convolution import dlc_pkg::*; #(
	parameter int MAX_TAPS    = DEF_MAX_TAPS,
	parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [CFG_BITS-1:0]           cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          opcode,
	input  logic [TAP_IDX_BITS-1:0]       tap_index,
	input  logic signed [SAMPLE_BITS-1:0] value,
	input  logic                          last_sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic signed [RESULT_BITS-1:0] result,
	output logic                          last_result
);

	localparam int KW = $clog2(MAX_TAPS + 1);

	logic [CFG_BITS-1:0]           kernel_length_q;
	logic [31:0]                   kl_w;
	logic [KW-1:0]                 k_eff;
	cell_ctl_t                     ctl;
	out_ctl_t                      octl;
	logic signed [SAMPLE_BITS-1:0] samp_w [0:MAX_TAPS];
	logic signed [RESULT_BITS-1:0] psum_w [0:MAX_TAPS];
	logic signed [RESULT_BITS-1:0] result_q;
	logic                          last_result_q;

	// kernel length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kernel_length_q <= CFG_BITS'(1);
		end else if (cfg_we) begin
			kernel_length_q <= cfg_wdata;
		end
	end

	// clamp to 1..MAX_TAPS
	assign kl_w = 32'(kernel_length_q);

	always_comb begin
		if (kl_w == 32'd0) begin
			k_eff = KW'(1);
		end else if (kl_w > 32'(MAX_TAPS)) begin
			k_eff = KW'(MAX_TAPS);
		end else begin
			k_eff = KW'(kl_w);
		end
	end

	dlc_ctrl #(
		.MAX_TAPS (MAX_TAPS),
		.KW       (KW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.last_sample (last_sample),
		.k_eff       (k_eff),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.ctl         (ctl),
		.octl        (octl)
	);

	// chain head: new sample or a zero for the tail, empty sum
	assign samp_w[0] = ctl.zero_in ? '0 : value;
	assign psum_w[0] = '0;

	for (genvar i = 0; i < MAX_TAPS; i++) begin : g_cell
		dlc_cell #(
			.SAMPLE_BITS (SAMPLE_BITS),
			.IDX         (i),
			.KW          (KW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.tap_index (tap_index),
			.tap_value (value),
			.k_eff     (k_eff),
			.samp_in   (samp_w[i]),
			.samp_out  (samp_w[i+1]),
			.psum_in   (psum_w[i]),
			.psum_out  (psum_w[i+1])
		);
	end

	// output register
	always_ff @(posedge clk) begin
		if (octl.cap) begin
			result_q      <= psum_w[MAX_TAPS];
			last_result_q <= octl.last;
		end
	end

	assign result      = result_q;
	assign last_result = last_result_q;

`ifndef SYNTHESIS
	a_no_shift_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.shift && ctl.clear))
		else $error("delay line shifted and cleared together");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		octl.cap |-> (!out_valid || out_ready))
		else $error("result loaded over a pending beat");

	a_busy_after_sample: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && opcode == OP_SAMPLE) |=> !in_ready)
		else $error("input taken while a sample is in flight");

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(octl.cap && octl.last) |-> ctl.clear)
		else $error("final result without delay line clear");
`endif

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb: testbench for direct_linear_convolution
// Runs a directed table after reset and then random streams of tap writes and
// samples over several kernel lengths. Both handshakes idle at random, and the
// result side holds off once for a long stretch. Every result beat is compared
// with a typed result or a model of the tap store, delay line and kernel length.
// ----------------------------------------------------------------------------
module tb import dlc_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAX_TAPS       = DEF_MAX_TAPS;
	localparam int SAMPLE_BITS    = DEF_SAMPLE_BITS;
	localparam int DRAIN_CYCLES   = MAX_TAPS + 16;
	localparam int HOLD_CYCLES    = 400;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DIR_COUNT      = 21;
	localparam int PHASE_COUNT    = 8;
	localparam int PHASE_BEATS    = 45;

	typedef enum logic [0:0] {ROW_BEAT, ROW_CFG} row_kind_t;

	// one row of the directed table
	typedef struct packed {
		row_kind_t                kind;
		logic                     op;
		logic [TAP_IDX_BITS-1:0]  idx;
		logic [SAMPLE_BITS-1:0]   val;
		logic                     last;
		logic                     typed;    // result below is given by hand
		logic [RESULT_BITS-1:0]   res;
		logic                     res_last;
		logic [CFG_BITS-1:0]      cfg;
	} stim_row_t;

	typedef struct {
		logic signed [RESULT_BITS-1:0] result;
		logic                          last;
	} conv_out_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_BITS-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic opcode = OP_TAP;
	logic [TAP_IDX_BITS-1:0] tap_index = '0;
	logic signed [SAMPLE_BITS-1:0] value = '0;
	logic last_sample = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [RESULT_BITS-1:0] result;
	logic last_result;

	// model state
	logic signed [SAMPLE_BITS-1:0] tap_mem [MAX_TAPS];
	logic signed [SAMPLE_BITS-1:0] delay_line [MAX_TAPS];
	logic [CFG_BITS-1:0] kernel_len;

	conv_out_t conv_expected [$];
	conv_out_t head;
	stim_row_t dir_rows [DIR_COUNT];
	logic [CFG_BITS-1:0] phase_len [PHASE_COUNT];

	int mismatch_count = 0;
	int results_seen = 0;
	int idle_cycles = 0;
	int send_calm = 0;
	int recv_calm = 0;

	direct_linear_convolution #(
		.MAX_TAPS(MAX_TAPS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.tap_index(tap_index),
		.value(value),
		.last_sample(last_sample),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result(result),
		.last_result(last_result)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// cycles to wait before a beat; occasionally a calm run with no gaps
	function automatic int pick_wait(inout int calm_left);
		if (calm_left > 0) begin
			calm_left = calm_left - 1;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			calm_left = $urandom_range(8, 30);
		return $urandom_range(0, 18);
	endfunction

	// sample or tap value, biased toward the corners
	function automatic logic [SAMPLE_BITS-1:0] pick_value();
		case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'h0000;
			3: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic void shift_line(input logic signed [SAMPLE_BITS-1:0] s);
		for (int i = MAX_TAPS - 1; i > 0; i--)
			delay_line[i] = delay_line[i-1];
		delay_line[0] = s;
	endfunction

	// sum of tap times delayed sample over the first k taps
	function automatic logic signed [RESULT_BITS-1:0] conv_sum(input int k);
		logic signed [RESULT_BITS-1:0] acc;
		logic signed [RESULT_BITS-1:0] a;
		logic signed [RESULT_BITS-1:0] b;
		acc = '0;
		for (int i = 0; i < k; i++) begin
			a = tap_mem[i];
			b = delay_line[i];
			acc = acc + a * b;
		end
		return acc;
	endfunction

	// update the model for one accepted beat; queue its first result when keep is set, tail results always
	task automatic predict_beat(input logic op, input logic [TAP_IDX_BITS-1:0] idx,
			input logic [SAMPLE_BITS-1:0] val, input logic last, input bit keep);
		int k;
		conv_out_t r;
		if (op == OP_TAP) begin
			tap_mem[idx] = val;
		end else begin
			k = (kernel_len == 0) ? 1 : ((kernel_len > MAX_TAPS) ? MAX_TAPS : kernel_len);
			shift_line(val);
			r.result = conv_sum(k);
			r.last = last && (k == 1);
			if (keep)
				conv_expected.push_back(r);
			// tail of the convolution, zeros shifted in
			if (last) begin
				for (int t = 1; t < k; t++) begin
					shift_line('0);
					r.result = conv_sum(k);
					r.last = (t == k - 1);
					conv_expected.push_back(r);
				end
				for (int i = 0; i < MAX_TAPS; i++)
					delay_line[i] = '0;
			end
		end
	endtask

	// offer one input beat and wait for it to be taken; starts and ends at a falling edge
	task automatic drive_beat(input logic op, input logic [TAP_IDX_BITS-1:0] idx,
			input logic [SAMPLE_BITS-1:0] val, input logic last);
		int gap;
		gap = pick_wait(send_calm);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		tap_index <= idx;
		value <= val;
		last_sample <= last;
		do @(posedge clk); while (in_ready !== 1'b1);
		@(negedge clk);
	endtask

	// write kernel_length once the block has gone quiet
	task automatic set_length(input logic [CFG_BITS-1:0] len);
		in_valid <= 1'b0;
		while (conv_expected.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= len;
		kernel_len = len;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// random beat for the stream phases: mostly samples, some tap writes
	task automatic random_beat();
		logic op;
		logic last;
		op = ($urandom_range(0, 4) == 0) ? OP_TAP : OP_SAMPLE;
		last = (op == OP_TAP) ? 1'($urandom) : ($urandom_range(0, 9) == 0);
		begin
			logic [TAP_IDX_BITS-1:0] idx;
			logic [SAMPLE_BITS-1:0] val;
			idx = TAP_IDX_BITS'($urandom);
			val = pick_value();
			drive_beat(op, idx, val, last);
			predict_beat(op, idx, val, last, 1'b1);
		end
	endtask

	// stimulus
	initial begin
		for (int i = 0; i < MAX_TAPS; i++) begin
			tap_mem[i] = '0;
			delay_line[i] = '0;
		end
		kernel_len = 7'd1;

		dir_rows = '{
			// kernel length one after reset; tap write ignores last_sample
			'{ROW_BEAT, OP_TAP,    6'd0,  16'h7FFF, 1'b1, 1'b0, 40'sd0,           1'b0, 7'd0},
			'{ROW_BEAT, OP_SAMPLE, 6'd0,  16'h7FFF, 1'b0, 1'b1, 40'sd1073676289,  1'b0, 7'd0},
			'{ROW_BEAT, OP_SAMPLE, 6'd0,  16'h8000, 1'b0, 1'b1, -40'sd1073709056, 1'b0, 7'd0},
			'{ROW_BEAT, OP_SAMPLE, 6'd0,  16'h0000, 1'b1, 1'b1, 40'sd0,           1'b1, 7'd0},
			'{ROW_BEAT, OP_TAP,    6'd0,  16'h8000, 1'b0, 1'b0, 40'sd0,           1'b0, 7'd0},
			'{ROW_BEAT, OP_SAMPLE, 6'd0,  16'h8000, 1'b0, 1'b1, 40'sd1073741824,  1'b0, 7'd0},
			'{ROW_BEAT, OP_SAMPLE, 6'd0,  16'h7FFF, 1'b1, 1'b1, -40'sd1073709056, 1'b1, 7'd0},
			'{ROW_BEAT, OP_TAP,    6'd63, 16'hFFFF, 1'b0, 1'b0, 40'sd0,           1'b0, 7'd0},
			'{ROW_BEAT, OP_TAP,    6'd1,  16'h8000, 1'b0, 1'b0, 40'sd0,           1'b0, 7'd0},
			// two taps, stream with a tail, then a tap change mid-stream
			'{ROW_CFG,  OP_TAP,    6'd0,  16'h0000, 1'b0, 1'b0, 40'sd0,           1'b0, 7'd2},
			'{ROW_BEAT, OP_SAMPLE, 6'd0,  16'h8000, 1'b0, 1'b0, 40'sd0,           1'b0, 7'd0},
			'{ROW_BEAT, OP_SAMPLE, 6'd0,  16'h8000, 1'b1, 1'b0, 40'sd0,           1'b0, 7'd0},
			'{ROW_BEAT, OP_TAP,    6'd1,  16'h7FFF, 1'b0, 1'b0, 40'sd0,           1'b0, 7'd0},
			'{ROW_BEAT, OP_SAMPLE, 6'd0,  16'h0001, 1'b0, 1'b0, 40'sd0,           1'b0, 7'd0},
			'{ROW_BEAT, OP_SAMPLE, 6'd0,  16'h7FFF, 1'b0, 1'b0, 40'sd0,           1'b0, 7'd0},
			// zero length acts as one
			'{ROW_CFG,  OP_TAP,    6'd0,  16'h0000, 1'b0, 1'b0, 40'sd0,           1'b0, 7'd0},
			'{ROW_BEAT, OP_SAMPLE, 6'd0,  16'h7FFF, 1'b1, 1'b1, -40'sd1073709056, 1'b1, 7'd0},
			// three taps
			'{ROW_BEAT, OP_TAP,    6'd2,  16'h3039, 1'b0, 1'b0, 40'sd0,           1'b0, 7'd0},
			'{ROW_CFG,  OP_TAP,    6'd0,  16'h0000, 1'b0, 1'b0, 40'sd0,           1'b0, 7'd3},
			'{ROW_BEAT, OP_SAMPLE, 6'd0,  16'hFFFF, 1'b0, 1'b0, 40'sd0,           1'b0, 7'd0},
			'{ROW_BEAT, OP_SAMPLE, 6'd0,  16'h0064, 1'b1, 1'b0, 40'sd0,           1'b0, 7'd0}
		};

		// lengths above MAX_TAPS act as MAX_TAPS; last one drawn at random
		phase_len = '{7'd127, 7'd2, 7'd64, 7'd1, 7'd5, 7'd100, 7'd17, 7'd1};
		phase_len[PHASE_COUNT-1] = CFG_BITS'($urandom_range(1, MAX_TAPS));

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table; a typed result goes ahead of any tail the model adds
		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == ROW_CFG) begin
				set_length(dir_rows[i].cfg);
			end else begin
				drive_beat(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].val, dir_rows[i].last);
				if (dir_rows[i].typed && dir_rows[i].op == OP_SAMPLE) begin
					head.result = $signed(dir_rows[i].res);
					head.last = dir_rows[i].res_last;
					conv_expected.push_back(head);
				end
				predict_beat(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].val,
					dir_rows[i].last, !dir_rows[i].typed);
			end
		end

		// load every tap so longer kernels never read an unwritten one
		for (int i = 0; i < MAX_TAPS; i++) begin
			logic [SAMPLE_BITS-1:0] val;
			val = pick_value();
			drive_beat(OP_TAP, TAP_IDX_BITS'(i), val, 1'($urandom));
			predict_beat(OP_TAP, TAP_IDX_BITS'(i), val, 1'b0, 1'b1);
		end

		// random streams over several kernel lengths
		foreach (phase_len[p]) begin
			set_length(phase_len[p]);
			repeat (PHASE_BEATS) random_beat();
		end

		// drain
		in_valid <= 1'b0;
		while (conv_expected.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && conv_expected.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// result side: random stalls, one long hold-off while input is still being offered
	initial begin
		int stall;
		bit held;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!held && results_seen >= 40) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				stall = pick_wait(recv_calm);
				if (stall == 0) begin
					out_ready <= 1'b1;
				end else begin
					out_ready <= 1'b0;
					do @(posedge clk); while (out_valid !== 1'b1);
					repeat (stall) @(negedge clk);
					out_ready <= 1'b1;
				end
			end
			do @(posedge clk); while (out_valid !== 1'b1);
		end
	end

	// compare each result beat with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_seen = results_seen + 1;
			if (conv_expected.size() == 0) begin
				$error("unexpected result beat: result %0d last_result %0b", result, last_result);
				mismatch_count = mismatch_count + 1;
			end else begin
				head = conv_expected.pop_front();
				if (result !== head.result) begin
					$error("result: expected %0d, got %0d", head.result, result);
					mismatch_count = mismatch_count + 1;
				end
				if (last_result !== head.last) begin
					$error("last_result: expected %0b, got %0b", head.last, last_result);
					mismatch_count = mismatch_count + 1;
				end
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

endmodule

// ===== files.f =====
src/dlc_pkg.sv
src/dlc_cell.sv
src/dlc_ctrl.sv
src/direct_linear_convolution.sv
dv/tb.sv
